### rtl/core/ppoc_pkg.sv
// Shared types and codes for the push/pop order classifier.
`timescale 1ns / 1ps

package ppoc_pkg;

	localparam logic       MODE_PUSH        = 1'b0;
	localparam logic       MODE_POP         = 1'b1;

	localparam logic [2:0] VERDICT_NONE     = 3'd0;
	localparam logic [2:0] VERDICT_UNSURE   = 3'd1;
	localparam logic [2:0] VERDICT_QUEUE    = 3'd2;
	localparam logic [2:0] VERDICT_PRIORITY = 3'd3;
	localparam logic [2:0] VERDICT_STACK    = 3'd4;

	typedef struct packed {
		logic               mode;
		logic signed [31:0] value;
		logic               last;
	} in_item_t;

	typedef struct packed {
		logic [2:0] verdict;
		logic       overflow;
		logic       trace_end;
	} out_item_t;

	typedef struct packed {
		logic               ins;
		logic               shift;
		logic signed [31:0] value;
	} cell_ctl_t;

endpackage

### rtl/core/ppoc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ppoc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/core/ppoc_cell.sv
// One cell of the sorted chain that models the max-priority queue.
`timescale 1ns / 1ps

module ppoc_cell #(
	parameter int IDX = 0,
	parameter int CW  = 11
) (
	input  logic                clk,
	input  ppoc_pkg::cell_ctl_t ctl,
	input  logic [CW-1:0]       count,
	input  logic signed [31:0]  prev_val,
	input  logic                prev_ge,
	input  logic signed [31:0]  next_val,
	output logic signed [31:0]  val,
	output logic                ge
);

	logic signed [31:0] val_q;
	logic               occ;

	assign occ = count > CW'(IDX);
	assign ge  = occ && (val_q >= ctl.value);
	assign val = val_q;

	always_ff @(posedge clk) begin
		priority if (ctl.ins) begin
			if (!ge) begin
				val_q <= prev_ge ? ctl.value : prev_val;
			end
		end else if (ctl.shift) begin
			val_q <= next_val;
		end
	end

endmodule

### rtl/core/push_pop_order_classifier_top.sv
// An accepted item is registered in item_q, then its result in the output
// register once that is empty or read; no new item is taken before that. The
// sorted cell chain inserts or shifts as the result is registered.
// The next item is accepted while a result waits in the output register.
// Reset (arst_n low): counters, head and flags clear at once; stores and
// chain cells are not cleared and need no clearing pass.
`timescale 1ns / 1ps

module push_pop_order_classifier_top #(
	parameter int CAPACITY = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ppoc_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output ppoc_pkg::out_item_t out_data
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	localparam logic S_ACCEPT = 1'b0;
	localparam logic S_EXEC   = 1'b1;

	logic                state_q;
	ppoc_pkg::in_item_t  item_q;
	ppoc_pkg::out_item_t out_q;
	logic                out_valid_q;

	logic [CW-1:0] stk_cnt_q, fifo_cnt_q, pq_cnt_q;
	logic [AW-1:0] fifo_head_q;
	logic          cbs_q, cbf_q, cbp_q;

	logic          exec_go, is_push, is_pop;
	logic          stk_full, fifo_full, pq_full;
	logic [CW-1:0] stk_cnt_m1;
	logic [CW:0]   tail_sum, tail_wrap;
	logic [AW:0]   head_inc;
	logic [AW-1:0] head_next;
	logic          stk_we, fifo_we;
	logic [31:0]   stk_rdata, fifo_rdata;
	logic          cbs_n, cbf_n, cbp_n;
	logic          over;
	logic [1:0]    n_poss;
	logic [2:0]    verdict_n;

	ppoc_pkg::cell_ctl_t ctl;
	logic signed [31:0]  cell_val [CAPACITY];
	logic                cell_ge  [CAPACITY];

	assign in_ready  = (state_q == S_ACCEPT);
	assign exec_go   = (state_q == S_EXEC) && (!out_valid_q || out_ready);
	assign is_push   = (item_q.mode == ppoc_pkg::MODE_PUSH);
	assign is_pop    = (item_q.mode == ppoc_pkg::MODE_POP);
	assign stk_full  = stk_cnt_q  >= CW'(CAPACITY);
	assign fifo_full = fifo_cnt_q >= CW'(CAPACITY);
	assign pq_full   = pq_cnt_q   >= CW'(CAPACITY);

	assign stk_cnt_m1 = stk_cnt_q - CW'(1);
	assign tail_sum   = (CW+1)'(fifo_head_q) + (CW+1)'(fifo_cnt_q);
	assign tail_wrap  = (tail_sum >= (CW+1)'(CAPACITY)) ?
		tail_sum - (CW+1)'(CAPACITY) : tail_sum;
	assign head_inc   = (AW+1)'(fifo_head_q) + (AW+1)'(1);
	assign head_next  = (head_inc == (AW+1)'(CAPACITY)) ? AW'(0) : head_inc[AW-1:0];

	assign stk_we  = exec_go && is_push && cbs_q && !stk_full;
	assign fifo_we = exec_go && is_push && cbf_q && !fifo_full;

	ppoc_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_cnt_q[AW-1:0]),
		.wdata (item_q.value),
		.raddr (stk_cnt_m1[AW-1:0]),
		.rdata (stk_rdata)
	);

	ppoc_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_fifo_ram (
		.clk   (clk),
		.we    (fifo_we),
		.waddr (tail_wrap[AW-1:0]),
		.wdata (item_q.value),
		.raddr (fifo_head_q),
		.rdata (fifo_rdata)
	);

	assign ctl.ins   = exec_go && is_push && cbp_q && !pq_full;
	assign ctl.shift = exec_go && is_pop && (pq_cnt_q != '0);
	assign ctl.value = item_q.value;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_chain
		logic signed [31:0] prev_v, next_v;
		logic               prev_g;
		if (i == 0) begin : g_head
			assign prev_v = cell_val[0];
			assign prev_g = 1'b1;
		end else begin : g_body
			assign prev_v = cell_val[i-1];
			assign prev_g = cell_ge[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign next_v = cell_val[i];
		end else begin : g_mid
			assign next_v = cell_val[i+1];
		end
		ppoc_cell #(.IDX(i), .CW(CW)) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.count    (pq_cnt_q),
			.prev_val (prev_v),
			.prev_ge  (prev_g),
			.next_val (next_v),
			.val      (cell_val[i]),
			.ge       (cell_ge[i])
		);
	end

	always_comb begin
		cbs_n = cbs_q;
		cbf_n = cbf_q;
		cbp_n = cbp_q;
		over  = 1'b0;
		if (is_push) begin
			over = (cbs_q && stk_full) || (cbf_q && fifo_full) || (cbp_q && pq_full);
		end else begin
			if (stk_cnt_q == '0 || stk_rdata != item_q.value) begin
				cbs_n = 1'b0;
			end
			if (fifo_cnt_q == '0 || fifo_rdata != item_q.value) begin
				cbf_n = 1'b0;
			end
			if (pq_cnt_q == '0 || cell_val[0] != item_q.value) begin
				cbp_n = 1'b0;
			end
		end
		n_poss = 2'(cbs_n) + 2'(cbf_n) + 2'(cbp_n);
		priority if (n_poss == 2'd0) begin
			verdict_n = ppoc_pkg::VERDICT_NONE;
		end else if (n_poss != 2'd1) begin
			verdict_n = ppoc_pkg::VERDICT_UNSURE;
		end else if (cbf_n) begin
			verdict_n = ppoc_pkg::VERDICT_QUEUE;
		end else if (cbp_n) begin
			verdict_n = ppoc_pkg::VERDICT_PRIORITY;
		end else begin
			verdict_n = ppoc_pkg::VERDICT_STACK;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= in_data;
		end
		if (exec_go) begin
			out_q.verdict   <= verdict_n;
			out_q.overflow  <= over;
			out_q.trace_end <= item_q.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_ACCEPT;
			out_valid_q <= 1'b0;
			stk_cnt_q   <= '0;
			fifo_cnt_q  <= '0;
			pq_cnt_q    <= '0;
			fifo_head_q <= '0;
			cbs_q       <= 1'b1;
			cbf_q       <= 1'b1;
			cbp_q       <= 1'b1;
		end else begin
			unique case (state_q)
				S_ACCEPT: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (exec_go) begin
						state_q <= S_ACCEPT;
					end
				end
				default: begin
					state_q <= S_ACCEPT;
				end
			endcase

			if (exec_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (exec_go) begin
				if (item_q.last) begin
					stk_cnt_q   <= '0;
					fifo_cnt_q  <= '0;
					pq_cnt_q    <= '0;
					fifo_head_q <= '0;
					cbs_q       <= 1'b1;
					cbf_q       <= 1'b1;
					cbp_q       <= 1'b1;
				end else begin
					cbs_q <= cbs_n;
					cbf_q <= cbf_n;
					cbp_q <= cbp_n;
					if (is_push) begin
						if (stk_we) begin
							stk_cnt_q <= stk_cnt_q + CW'(1);
						end
						if (fifo_we) begin
							fifo_cnt_q <= fifo_cnt_q + CW'(1);
						end
						if (ctl.ins) begin
							pq_cnt_q <= pq_cnt_q + CW'(1);
						end
					end else begin
						if (stk_cnt_q != '0) begin
							stk_cnt_q <= stk_cnt_m1;
						end
						if (fifo_cnt_q != '0) begin
							fifo_cnt_q  <= fifo_cnt_q - CW'(1);
							fifo_head_q <= head_next;
						end
						if (ctl.shift) begin
							pq_cnt_q <= pq_cnt_q - CW'(1);
						end
					end
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef NO_ASSERTIONS
	a_counts_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		stk_cnt_q <= CW'(CAPACITY) && fifo_cnt_q <= CW'(CAPACITY) &&
		pq_cnt_q <= CW'(CAPACITY))
		else $error("store count beyond capacity");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		exec_go && item_q.last |=> stk_cnt_q == '0 && fifo_cnt_q == '0 &&
		pq_cnt_q == '0 && cbs_q && cbf_q && cbp_q)
		else $error("state not cleared after last item");

	a_pop_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		exec_go && is_pop |=> out_valid_q && !out_q.overflow)
		else $error("overflow flagged on pop");

	a_no_accept_in_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_EXEC && !in_ready)
		else $error("second item accepted while one is in progress");

	a_flags_only_fall: assert property (@(posedge clk) disable iff (!arst_n)
		exec_go && !item_q.last && !cbs_q |=> !cbs_q)
		else $error("stack flag restored within a trace");
`endif

endmodule
